@@ sv/tdf_pkg.sv @@
// shared types for the trial division factorizer
// controller states, datapath command and status bundles; no dependencies
`default_nettype none

package tdf_pkg;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_TEST,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FOUND,
		ST_FINAL,
		ST_EMIT_REM,
		ST_EMIT_EMPTY
	} state_t;

	// source of a loaded result
	typedef enum logic [1:0] {
		SEL_EMPTY,
		SEL_PEND,
		SEL_REM
	} out_sel_t;

	// controller to datapath
	typedef struct packed {
		logic     load;
		logic     div_start;
		logic     take;
		logic     next_div;
		logic     out_load;
		out_sel_t out_sel;
		logic     out_last;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rem_le1;
		logic rem_is1;
		logic sq_le_rem;
		logic div_done;
		logic div_exact;
		logic pend_v;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ sv/tdf_div.sv @@
// restoring divider, one quotient bit per cycle
// standalone unit, no package dependency
`default_nettype none

module tdf_div #(
	parameter int W  = 31,
	parameter int DW = 17
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [W-1:0]  dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [W-1:0]       quotient,
	output logic [DW-1:0]      remainder
);

	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quo_q;
	logic [DW-1:0] rem_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	// partial remainder shifted by one dividend bit
	assign trial = {rem_q, quo_q[W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift and subtract
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

@@ sv/tdf_datapath.sv @@
// datapath: remaining value, trial divisor and its square, pending factor,
// result register; uses tdf_pkg and tdf_div
`default_nettype none

module tdf_datapath #(
	parameter int VALUE_BITS = 31
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tdf_pkg::dp_cmd_t      cmd,
	output tdf_pkg::dp_stat_t          stat,
	input  wire logic [VALUE_BITS-1:0] n_value,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [VALUE_BITS-1:0]      factor,
	output logic                       is_last,
	output logic                       is_empty,
	output logic                       is_semiprime
);

	import tdf_pkg::*;

	localparam int W  = VALUE_BITS;
	localparam int DW = (W + 1) / 2 + 1;
	localparam int SW = 2 * DW;

	logic [W-1:0]  rem_q;
	logic [DW-1:0] div_q;
	logic [SW-1:0] sq_q;
	logic [1:0]    cnt_q;
	logic [W-1:0]  first_q;
	logic [W-1:0]  pend_q;
	logic          pend_v_q;
	logic          out_valid_q;
	logic [W-1:0]  factor_q;
	logic          last_q;
	logic          empty_q;
	logic          semi_q;
	logic          div_done;
	logic [W-1:0]  quo;
	logic [DW-1:0] rmd;
	logic          out_free;
	logic [W-1:0]  out_f;
	logic          out_semi;

	tdf_div #(.W(W), .DW(DW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (rem_q),
		.divisor   (div_q),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rmd)
	);

	// factoring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
		end else if (cmd.load) begin
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
		end else if (cmd.take) begin
			if (cnt_q != 2'd3) cnt_q <= cnt_q + 2'd1;
			pend_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= n_value;
			div_q <= DW'(2);
			sq_q  <= SW'(4);
		end else if (cmd.take) begin
			rem_q  <= quo;
			pend_q <= W'(div_q);
			if (cnt_q == 2'd0) first_q <= W'(div_q);
		end else if (cmd.next_div) begin
			// (d+1)^2 = d^2 + 2d + 1
			div_q <= div_q + DW'(1);
			sq_q  <= sq_q + SW'({div_q, 1'b1});
		end
	end

	// result selection and semiprime flag
	always_comb begin
		out_f    = '0;
		out_semi = 1'b0;
		case (cmd.out_sel)
			SEL_PEND: begin
				out_f    = pend_q;
				out_semi = cmd.out_last && (cnt_q == 2'd2) && (first_q != pend_q);
			end
			SEL_REM: begin
				out_f    = rem_q;
				out_semi = (cnt_q == 2'd1) && (first_q != rem_q);
			end
			default: begin
				out_f    = '0;
				out_semi = 1'b0;
			end
		endcase
	end

	// result register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			factor_q <= out_f;
			last_q   <= cmd.out_last;
			empty_q  <= (cmd.out_sel == SEL_EMPTY);
			semi_q   <= out_semi;
		end
	end

	// status to controller
	always_comb begin
		stat.rem_le1   = rem_q <= W'(1);
		stat.rem_is1   = rem_q == W'(1);
		stat.sq_le_rem = sq_q <= SW'(rem_q);
		stat.div_done  = div_done;
		stat.div_exact = rmd == '0;
		stat.pend_v    = pend_v_q;
		stat.out_free  = out_free;
	end

	assign out_valid    = out_valid_q;
	assign factor       = factor_q;
	assign is_last      = last_q;
	assign is_empty     = empty_q;
	assign is_semiprime = semi_q;

endmodule

`default_nettype wire

@@ sv/tdf_ctrl.sv @@
// controller state machine for the trial division loop
// uses tdf_pkg; drives the datapath command bundle
`default_nettype none

module tdf_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire tdf_pkg::dp_stat_t stat,
	output tdf_pkg::dp_cmd_t       cmd
);

	import tdf_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:       if (in_valid) state_d = ST_START;
			ST_START:      state_d = stat.rem_le1 ? ST_EMIT_EMPTY : ST_TEST;
			ST_TEST:       state_d = stat.sq_le_rem ? ST_DIV_GO : ST_FINAL;
			ST_DIV_GO:     state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (stat.div_done) state_d = stat.div_exact ? ST_FOUND : ST_TEST;
			end
			ST_FOUND: begin
				if (!stat.pend_v || stat.out_free) state_d = ST_DIV_GO;
			end
			ST_FINAL: begin
				if (stat.rem_is1) begin
					if (stat.out_free) state_d = ST_IDLE;
				end else if (!stat.pend_v) begin
					state_d = ST_EMIT_REM;
				end else if (stat.out_free) begin
					state_d = ST_EMIT_REM;
				end
			end
			ST_EMIT_REM:   if (stat.out_free) state_d = ST_IDLE;
			ST_EMIT_EMPTY: if (stat.out_free) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		cmd.out_sel = SEL_EMPTY;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_START: begin
			end
			ST_TEST: begin
			end
			ST_DIV_GO: begin
				cmd.div_start = 1'b1;
			end
			ST_DIV_WAIT: begin
				cmd.next_div = stat.div_done && !stat.div_exact;
			end
			ST_FOUND: begin
				// push out the previous factor, keep the new one pending
				if (!stat.pend_v || stat.out_free) begin
					cmd.take     = 1'b1;
					cmd.out_load = stat.pend_v;
					cmd.out_sel  = SEL_PEND;
				end
			end
			ST_FINAL: begin
				cmd.out_sel  = SEL_PEND;
				cmd.out_last = stat.rem_is1;
				cmd.out_load = stat.pend_v && stat.out_free;
			end
			ST_EMIT_REM: begin
				cmd.out_sel  = SEL_REM;
				cmd.out_last = 1'b1;
				cmd.out_load = stat.out_free;
			end
			ST_EMIT_EMPTY: begin
				cmd.out_sel  = SEL_EMPTY;
				cmd.out_last = 1'b1;
				cmd.out_load = stat.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ sv/trial_division_factorizer_unit.sv @@
// top level of the trial division factorizer; uses tdf_pkg, tdf_ctrl, tdf_datapath
// each trial divisor costs one run of the one-bit-per-cycle divider, and each factor found costs
// another run with the same divisor; an input of one passes through ST_START and ST_EMIT_EMPTY
// straight to the output register, without any divider run
// one request at a time: the next is taken once the last result sits in the output register
// arst_n clears the controller, the divider and the output valid; no clearing pass is needed
`default_nettype none

module trial_division_factorizer_unit #(
	parameter int VALUE_BITS = 31
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [VALUE_BITS-1:0] n_value,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [VALUE_BITS-1:0]      factor,
	output logic                       is_last,
	output logic                       is_empty,
	output logic                       is_semiprime
);

	import tdf_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	tdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	tdf_datapath #(.VALUE_BITS(VALUE_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.n_value      (n_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.factor       (factor),
		.is_last      (is_last),
		.is_empty     (is_empty),
		.is_semiprime (is_semiprime)
	);

endmodule

`default_nettype wire

@@ sv/tdf_checker.sv @@
// port-level checks for the trial division factorizer
// bound to trial_division_factorizer_unit; no package dependency
`default_nettype none

module tdf_checker #(
	parameter int VALUE_BITS = 31
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_stall,
	input wire logic [VALUE_BITS-1:0] n_value,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic [VALUE_BITS-1:0] factor,
	input wire logic                  is_last,
	input wire logic                  is_empty,
	input wire logic                  is_semiprime
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(factor) && $stable(is_last))
		else $error("stalled result changed");

	// one request at a time: busy right after taking one
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while busy");

	// an empty result is the only and last one, with a zero factor
	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> is_last && (factor == '0) && !is_semiprime)
		else $error("malformed empty result");

	// semiprime only on the last result; real factors are never zero
	a_semi_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_empty |-> (factor != '0) && (is_last || !is_semiprime))
		else $error("bad factor result");

endmodule

bind trial_division_factorizer_unit tdf_checker #(.VALUE_BITS(VALUE_BITS)) u_tdf_checker (.*);

`default_nettype wire

@@ test/factor_checker.sv @@
// checker for the trial division factorizer: watches both channels, predicts the prime
// factors of every accepted request and compares each result in order; no dependencies
`default_nettype none

module factor_checker #(
	parameter int VB = 31
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_stall,
	input  wire logic [VB-1:0] n_value,
	input  wire logic          out_valid,
	input  wire logic          out_stall,
	input  wire logic [VB-1:0] factor,
	input  wire logic          is_last,
	input  wire logic          is_empty,
	input  wire logic          is_semiprime,
	output int                 mismatches,
	output int                 outstanding,
	output int                 results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// one expected factor result, tagged with the request it came from
	typedef struct {
		logic [VB-1:0] value;
		logic          last;
		logic          empty;
		logic          semi;
		int unsigned   req;
		logic [VB-1:0] number;
	} factor_item_t;

	factor_item_t factor_queue[$];
	int unsigned  requests_seen = 0;

	task automatic report_mismatch(input string msg);
		if (mismatches < 40) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
		mismatches++;
	endtask

	// trial division in plain integers, one queue entry per prime factor
	function automatic void expand_prime_factors(input logic [VB-1:0] number);
		longint unsigned rest;
		longint unsigned divisor;
		longint unsigned primes [0:63];
		int              count;
		int              k;
		logic            semi;
		factor_item_t    item;
		rest = number;
		count = 0;
		item.req = requests_seen;
		item.number = number;
		// zero and one give a single empty result
		if (rest <= 1) begin
			item.value = '0;
			item.last = 1'b1;
			item.empty = 1'b1;
			item.semi = 1'b0;
			factor_queue = {factor_queue, item};
			return;
		end
		divisor = 2;
		while (divisor * divisor <= rest) begin
			while (rest % divisor == 0 && count < 64) begin
				rest = rest / divisor;
				primes[count] = divisor;
				count++;
			end
			divisor++;
		end
		// what is left above one is itself prime
		if (rest != 1 && count < 64) begin
			primes[count] = rest;
			count++;
		end
		semi = (count == 2 && primes[0] != primes[1]);
		for (k = 0; k < count; k++) begin
			item.value = primes[k][VB-1:0];
			item.last = (k == count - 1);
			item.empty = 1'b0;
			item.semi = (k == count - 1) ? semi : 1'b0;
			factor_queue = {factor_queue, item};
		end
	endfunction

	// compare one accepted result with the oldest expectation
	task automatic check_factor_result();
		factor_item_t want;
		if (factor_queue.size() == 0) begin
			report_mismatch($sformatf("result with nothing expected: factor %0d last %0b",
				factor, is_last));
			return;
		end
		want = factor_queue.pop_front();
		results_checked++;
		if (factor !== want.value)
			report_mismatch($sformatf("request %0d (n=%0d): factor %0d, want %0d",
				want.req, want.number, factor, want.value));
		if (is_last !== want.last)
			report_mismatch($sformatf("request %0d (n=%0d): is_last %0b, want %0b",
				want.req, want.number, is_last, want.last));
		if (is_empty !== want.empty)
			report_mismatch($sformatf("request %0d (n=%0d): is_empty %0b, want %0b",
				want.req, want.number, is_empty, want.empty));
		if (is_semiprime !== want.semi)
			report_mismatch($sformatf("request %0d (n=%0d): is_semiprime %0b, want %0b",
				want.req, want.number, is_semiprime, want.semi));
	endtask

	// sample both handshakes at every rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expand_prime_factors(n_value);
				requests_seen++;
			end
			if (out_valid && !out_stall) begin
				check_factor_result();
			end
			outstanding = factor_queue.size();
		end
	end

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// top of the factorizer test: clock, reset, request and result sides, verdict
// depends on trial_division_factorizer_unit and factor_checker
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VB = 31;
	localparam int LONG_HOLD = 3000;
	localparam longint RUN_LIMIT = 12_000_000;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	logic [VB-1:0] n_value = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	logic [VB-1:0] factor;
	logic          is_last;
	logic          is_empty;
	logic          is_semiprime;

	int mismatches;
	int outstanding;
	int results_checked;

	int unsigned   requests_sent = 0;
	int unsigned   holds_asked = 0;
	int unsigned   drains = 0;
	longint        cycle_count = 0;
	logic [VB-1:0] directed_values [0:19];

	trial_division_factorizer_unit #(
		.VALUE_BITS(VB)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.n_value     (n_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.factor      (factor),
		.is_last     (is_last),
		.is_empty    (is_empty),
		.is_semiprime(is_semiprime)
	);

	factor_checker #(
		.VB(VB)
	) checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.n_value        (n_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.factor         (factor),
		.is_last        (is_last),
		.is_empty       (is_empty),
		.is_semiprime   (is_semiprime),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.results_checked(results_checked)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// offer one request, with a random gap unless a burst is running
	task automatic push_number(input logic [VB-1:0] value, input bit burst);
		int unsigned gap;
		gap = burst ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		n_value <= value;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		requests_sent++;
	endtask

	// input idle until every expected result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		drains++;
	endtask

	// mostly cheap numbers; smooth products and shifted odd cores reach the high bits
	function automatic logic [VB-1:0] pick_number();
		int unsigned     kind;
		int unsigned     f;
		int unsigned     shift;
		longint unsigned p;
		logic [VB-1:0]   v;
		kind = $urandom_range(0, 99);
		if (kind < 5) begin
			v = VB'($urandom_range(0, 1));
		end else if (kind < 40) begin
			v = VB'($urandom_range(2, 1023));
		end else if (kind < 55) begin
			v = VB'($urandom_range(1024, 65535));
		end else if (kind < 80) begin
			p = 1;
			repeat (40) begin
				f = $urandom_range(2, 60);
				if (p * f < 64'h8000_0000) p = p * f;
			end
			v = p[VB-1:0];
		end else begin
			f = $urandom_range(1, 4095) | 1;
			shift = $urandom_range(0, 19);
			p = longint'(f) << shift;
			v = p[VB-1:0];
		end
		return v;
	endfunction

	// result side: random stall per result, quiet stretches, one long hold-off
	initial begin
		int unsigned wait_cycles;
		int unsigned stretch_left;
		int unsigned holds_done;
		bit          no_idle;
		stretch_left = 0;
		holds_done = 0;
		no_idle = 1'b0;
		forever begin
			if (stretch_left == 0) begin
				no_idle = ($urandom_range(0, 3) == 0);
				stretch_left = 24;
			end
			stretch_left--;
			wait_cycles = no_idle ? 0 : $urandom_range(0, 7);
			if (holds_done != holds_asked) begin
				wait_cycles = LONG_HOLD;
				holds_done++;
			end
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// run limit
	initial begin
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results still expected",
			cycle_count, outstanding);
		$display("*** FAILED ***");
		$finish;
	end

	// request side and verdict
	initial begin
		int unsigned blk;
		int unsigned k;
		bit          burst;
		// one and zero, small primes, squares, semiprimes, 2^30 with thirty factors,
		// large smooth values and the largest 31-bit prime
		directed_values = '{
			31'd1, 31'd0, 31'd2, 31'd3, 31'd4, 31'd6, 31'd9, 31'd12, 31'd35, 31'd97,
			31'd253, 31'd1024, 31'd30030, 31'd63001, 31'd131042, 31'd1073741824,
			31'd1162261467, 31'd2146992128, 31'd2147483646, 31'd2147483647
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests
		for (k = 0; k < 20; k++) begin
			push_number(directed_values[k], 1'b0);
		end
		drain_results();

		// random requests in blocks; the third block runs into the long output hold
		for (blk = 0; blk < 8; blk++) begin
			burst = ($urandom_range(0, 3) == 0);
			if (blk == 2) begin
				holds_asked++;
				burst = 1'b1;
			end
			for (k = 0; k < 10; k++) begin
				push_number((blk == 2) ? VB'($urandom_range(2, 200)) : pick_number(), burst);
			end
			if (blk == 2 || $urandom_range(0, 3) == 0) begin
				drain_results();
			end
		end
		drain_results();
		repeat (4 * (VB + 4)) @(posedge clk);

		$display("run covered %0d requests, 20 directed (one, zero, squares, semiprimes, 2^30, 2^31-1)",
			requests_sent);
		$display("%0d results checked under random stalls, one %0d-cycle output hold, %0d drains",
			results_checked, LONG_HOLD, drains);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire
